/* src/ftrc_pkg.sv */
// Package for the five-tuple rule classifier: field widths, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package ftrc_pkg;
	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;
	localparam int CODE_W = 8;
	localparam int HIT_W = 6;
	localparam int CNT_W = 7;
	localparam int REG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;
	localparam int DEF_RULE_DEPTH = 64;
	localparam int RULE_W = 2 * CODE_W + 2 * ADDR_W + 2 * PORT_W;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_RULES = 1'b1;
	localparam logic [CODE_W-1:0] ACT_PERMIT_A = 8'd48;
	localparam logic [CODE_W-1:0] ACT_PERMIT_B = 8'd49;
	localparam logic [CODE_W-1:0] ACT_PERMIT_C = 8'd50;
	localparam logic [CODE_W-1:0] PROTO_ICMP = 8'd1;

	typedef struct packed {
		logic [CODE_W-1:0] action;
		logic [CODE_W-1:0] proto;
		logic [ADDR_W-1:0] src_addr;
		logic [PORT_W-1:0] src_port;
		logic [ADDR_W-1:0] dst_addr;
		logic [PORT_W-1:0] dst_port;
	} rule_t;

	// Request handed from the front to the back part
	typedef struct packed {
		logic opcode;
		logic direction;
		logic [HIT_W-1:0] slot;
		logic [CODE_W-1:0] action;
		logic [CODE_W-1:0] proto;
		logic [ADDR_W-1:0] first_addr;
		logic [PORT_W-1:0] first_port;
		logic [ADDR_W-1:0] second_addr;
		logic [PORT_W-1:0] second_port;
	} req_t;

	typedef struct packed {
		logic verdict;
		logic matched;
		logic [HIT_W-1:0] hit_index;
		logic [CODE_W-1:0] hit_action;
	} res_t;
endpackage

/* src/ftrc_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on ftrc_pkg.
`timescale 1ns / 1ps
interface ftrc_in_if import ftrc_pkg::*; ();
	logic valid;
	logic ready;
	logic opcode;
	logic direction;
	logic [HIT_W-1:0] rule_slot;
	logic [CODE_W-1:0] rule_action_code;
	logic [CODE_W-1:0] proto_number;
	logic [ADDR_W-1:0] first_addr;
	logic [PORT_W-1:0] first_port;
	logic [ADDR_W-1:0] second_addr;
	logic [PORT_W-1:0] second_port;
	modport source (output valid, opcode, direction, rule_slot, rule_action_code,
		proto_number, first_addr, first_port, second_addr, second_port, input ready);
	modport sink (input valid, opcode, direction, rule_slot, rule_action_code,
		proto_number, first_addr, first_port, second_addr, second_port, output ready);
endinterface

interface ftrc_out_if import ftrc_pkg::*; ();
	logic valid;
	logic ready;
	logic verdict;
	logic matched;
	logic [HIT_W-1:0] hit_index;
	logic [CODE_W-1:0] hit_action;
	modport source (output valid, verdict, matched, hit_index, hit_action, input ready);
	modport sink (input valid, verdict, matched, hit_index, hit_action, output ready);
endinterface

/* src/ftrc_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ftrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* src/ftrc_queue.sv */
// Two-entry request queue between the front and back parts.
// Depends on ftrc_pkg.
`timescale 1ns / 1ps
module ftrc_queue import ftrc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output req_t pop_data
);
	req_t   mem_q [2];
	logic   wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign pop_data = mem_q[rp_q];

	// Store payload on push
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* src/ftrc_engine.sv */
// Back part: stores rules and scans them one at a time, popping no request mid-scan.
// Depends on ftrc_pkg and ftrc_ram.
`timescale 1ns / 1ps
module ftrc_engine import ftrc_pkg::*; #(
	parameter int RULE_DEPTH = DEF_RULE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic filter_enable,
	input  logic [CNT_W-1:0] rules_in_use,
	input  logic req_valid,
	input  req_t req,
	output logic req_pop,
	output logic res_valid,
	output res_t res,
	input  logic res_ready
);
	localparam int IW = $clog2(RULE_DEPTH) > 0 ? $clog2(RULE_DEPTH) : 1;
	localparam int LW = $clog2(RULE_DEPTH + 1) > CNT_W ? $clog2(RULE_DEPTH + 1) : CNT_W;
	localparam logic [1:0] ST_IDLE = 2'd0, ST_READ = 2'd1, ST_TEST = 2'd2;

	logic [1:0] state_q;
	logic [LW-1:0] k_q, limit_q;
	req_t cur_q;
	res_t res_q;
	logic out_v_q;
	rule_t rd;
	logic we;
	logic [IW-1:0] raddr;
	logic [LW-1:0] lim_w;
	logic hit, src_ok, dst_ok, permit;
	logic [ADDR_W-1:0] sa, da;
	logic [PORT_W-1:0] sp, dp;

	// Rule writes within the table depth
	assign we = (state_q == ST_IDLE) && req_valid && !out_v_q && req.opcode == OP_WRITE
		&& {{(LW-HIT_W){1'b0}}, req.slot} < LW'(RULE_DEPTH);
	assign raddr = k_q[IW-1:0];

	ftrc_ram #(.WIDTH(RULE_W), .DEPTH(RULE_DEPTH)) u_rules (
		.clk(clk), .we(we), .waddr(IW'(req.slot)),
		.wdata({req.action, req.proto, req.first_addr, req.first_port,
			req.second_addr, req.second_port}),
		.raddr(raddr), .rdata(rd));

	// Match the rule just read
	always_comb begin
		sa = cur_q.direction ? cur_q.second_addr : cur_q.first_addr;
		sp = cur_q.direction ? cur_q.second_port : cur_q.first_port;
		da = cur_q.direction ? cur_q.first_addr : cur_q.second_addr;
		dp = cur_q.direction ? cur_q.first_port : cur_q.second_port;
		src_ok = (rd.src_addr == '0 || rd.src_addr == sa)
			&& (rd.src_port == '0 || rd.src_port == sp);
		dst_ok = (rd.dst_addr == '0 || rd.dst_addr == da)
			&& (rd.dst_port == '0 || rd.dst_port == dp);
		hit = rd.proto == cur_q.proto && src_ok
			&& (dst_ok || (cur_q.direction && cur_q.proto == PROTO_ICMP));
		permit = rd.action == ACT_PERMIT_A || rd.action == ACT_PERMIT_B
			|| rd.action == ACT_PERMIT_C;
		lim_w = {{(LW-CNT_W){1'b0}}, rules_in_use};
		if (lim_w > LW'(RULE_DEPTH)) lim_w = LW'(RULE_DEPTH);
	end

	assign req_pop = (state_q == ST_IDLE) && req_valid && !out_v_q;
	assign res_valid = out_v_q;
	assign res = res_q;

	// Sequence: take a request, scan, present result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			k_q <= '0;
			limit_q <= '0;
		end else begin
			if (out_v_q && res_ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (req_pop && req.opcode == OP_CLASSIFY) begin
						if (!filter_enable || lim_w == '0) out_v_q <= 1'b1;
						else state_q <= ST_READ;
						limit_q <= lim_w;
					end
				end
				ST_READ: state_q <= ST_TEST;
				ST_TEST: begin
					if (hit || k_q + 1'b1 == limit_q) begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture request and result payload
	always_ff @(posedge clk) begin
		if (req_pop) begin
			cur_q <= req;
			res_q <= '0;
		end
		if (state_q == ST_TEST && hit) begin
			res_q.verdict <= !permit;
			res_q.matched <= 1'b1;
			res_q.hit_index <= HIT_W'(k_q);
			res_q.hit_action <= rd.action;
		end
	end
endmodule

/* src/five_tuple_rule_classifier.sv */
// Top level of the five-tuple rule classifier: config registers, queue, engine.
// Depends on ftrc_pkg, ftrc_if, ftrc_queue, ftrc_engine.
//
//   channel   dir  contents
//   in_ch     in   opcode, direction, slot, action, protocol, addresses, ports
//   out_ch    out  verdict, matched, hit_index, hit_action
//   cfg_*     in   write enable, register index, data
//
// A classify is popped from the queue, then scans rules one at a time, each with a
// RAM read then a compare, stopping at the first hit or the last rule in use; its
// result is registered and held until taken; a write is done when it is popped.
// The rule table is one registered-read RAM port, hence the read before each compare.
// Reset clears control only; rule contents are undefined until written.
// The front queue of two keeps accepting until full while the engine stalls on out_ch.
`timescale 1ns / 1ps
module five_tuple_rule_classifier import ftrc_pkg::*; #(
	parameter int RULE_DEPTH = DEF_RULE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ftrc_in_if.sink in_ch,
	ftrc_out_if.source out_ch
);
	logic en_q;
	logic [CNT_W-1:0] rules_q;
	logic full, empty, pop;
	req_t push_data, head;
	res_t res;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			rules_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE: en_q <= cfg_data[0];
				REG_RULES: rules_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = !full;
	assign push_data = '{opcode: in_ch.opcode, direction: in_ch.direction,
		slot: in_ch.rule_slot, action: in_ch.rule_action_code,
		proto: in_ch.proto_number, first_addr: in_ch.first_addr,
		first_port: in_ch.first_port, second_addr: in_ch.second_addr,
		second_port: in_ch.second_port};

	ftrc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(in_ch.valid && !full), .push_data(push_data),
		.full(full), .pop(pop), .empty(empty), .pop_data(head));

	ftrc_engine #(.RULE_DEPTH(RULE_DEPTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .filter_enable(en_q), .rules_in_use(rules_q),
		.req_valid(!empty), .req(head), .req_pop(pop),
		.res_valid(out_ch.valid), .res(res), .res_ready(out_ch.ready));

	assign out_ch.verdict = res.verdict;
	assign out_ch.matched = res.matched;
	assign out_ch.hit_index = res.hit_index;
	assign out_ch.hit_action = res.hit_action;
endmodule

/* test/ftrc_checker.sv */
// Checker for the five-tuple rule classifier: watches both channels, predicts verdicts.
// Depends on ftrc_pkg and ftrc_if; the configuration port is observed directly.
`timescale 1ns / 1ps
module ftrc_checker import ftrc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ftrc_in_if in_ch,
	ftrc_out_if out_ch,
	output int fail_count,
	output int verdicts_pending
);
	localparam int DEPTH = DEF_RULE_DEPTH;

	rule_t rule_shadow [DEPTH];
	logic shadow_enable;
	logic [CNT_W-1:0] shadow_rules;
	res_t verdict_queue [$];

	// Does rule k match the packet
	function automatic logic rule_matches(int k, logic outbound, logic [CODE_W-1:0] proto,
		logic [ADDR_W-1:0] loc_a, logic [PORT_W-1:0] loc_p,
		logic [ADDR_W-1:0] rem_a, logic [PORT_W-1:0] rem_p);
		rule_t r;
		logic [ADDR_W-1:0] sa;
		logic [PORT_W-1:0] sp;
		logic [ADDR_W-1:0] da;
		logic [PORT_W-1:0] dp;
		r = rule_shadow[k];
		if (r.proto != proto) return 1'b0;
		sa = outbound ? rem_a : loc_a;
		sp = outbound ? rem_p : loc_p;
		da = outbound ? loc_a : rem_a;
		dp = outbound ? loc_p : rem_p;
		if (!((r.src_addr == '0 || r.src_addr == sa) && (r.src_port == '0 || r.src_port == sp)))
			return 1'b0;
		if (outbound && proto == PROTO_ICMP) return 1'b1;
		return (r.dst_addr == '0 || r.dst_addr == da) && (r.dst_port == '0 || r.dst_port == dp);
	endfunction

	// First-match search over the rules in use
	function automatic res_t predict_verdict(logic outbound, logic [CODE_W-1:0] proto,
		logic [ADDR_W-1:0] loc_a, logic [PORT_W-1:0] loc_p,
		logic [ADDR_W-1:0] rem_a, logic [PORT_W-1:0] rem_p);
		res_t res;
		int limit;
		logic [CODE_W-1:0] code;
		res = '0;
		if (!shadow_enable) return res;
		limit = (shadow_rules > DEPTH) ? DEPTH : shadow_rules;
		for (int k = 0; k < limit; k++) begin
			if (rule_matches(k, outbound, proto, loc_a, loc_p, rem_a, rem_p)) begin
				code = rule_shadow[k].action;
				res.verdict = !(code == ACT_PERMIT_A || code == ACT_PERMIT_B ||
					code == ACT_PERMIT_C);
				res.matched = 1'b1;
				res.hit_index = k[HIT_W-1:0];
				res.hit_action = code;
				break;
			end
		end
		return res;
	endfunction

	assign verdicts_pending = verdict_queue.size();

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		int errs;
		if (!arst_n) begin
			shadow_enable <= 1'b1;
			shadow_rules <= '0;
			fail_count <= 0;
			verdict_queue.delete();
		end else begin
			errs = 0;
			// Track register writes
			if (cfg_we) begin
				if (cfg_index == REG_ENABLE) shadow_enable <= cfg_data[0];
				else if (cfg_index == REG_RULES) shadow_rules <= cfg_data;
			end
			// Take in a request
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.opcode == OP_WRITE) begin
					rule_shadow[in_ch.rule_slot] = '{in_ch.rule_action_code, in_ch.proto_number,
						in_ch.first_addr, in_ch.first_port, in_ch.second_addr, in_ch.second_port};
				end else begin
					verdict_queue.push_back(predict_verdict(in_ch.direction, in_ch.proto_number,
						in_ch.first_addr, in_ch.first_port, in_ch.second_addr, in_ch.second_port));
				end
			end
			// Compare a result against the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				if (verdict_queue.size() == 0) begin
					$error("unexpected result");
					errs++;
				end else begin
					want = verdict_queue.pop_front();
					if (out_ch.verdict !== want.verdict) begin
						$error("verdict: expected %0d, got %0d", want.verdict, out_ch.verdict);
						errs++;
					end
					if (out_ch.matched !== want.matched) begin
						$error("matched: expected %0d, got %0d", want.matched, out_ch.matched);
						errs++;
					end
					if (out_ch.hit_index !== want.hit_index) begin
						$error("hit_index: expected %0d, got %0d", want.hit_index, out_ch.hit_index);
						errs++;
					end
					if (out_ch.hit_action !== want.hit_action) begin
						$error("hit_action: expected %0d, got %0d", want.hit_action,
							out_ch.hit_action);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
	end
endmodule

/* test/five_tuple_rule_classifier_tb.sv */
// Stimulus and verdict for the five-tuple rule classifier.
// Depends on ftrc_pkg, ftrc_if, ftrc_checker and the block itself.
`timescale 1ns / 1ps
module five_tuple_rule_classifier_tb;
	import ftrc_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int fail_count;
	int verdicts_pending;
	int send_idle_pct;
	int sink_stall_pct;
	logic [ADDR_W-1:0] addr_pool [4];
	logic [PORT_W-1:0] port_pool [4];
	logic [CODE_W-1:0] proto_pool [4];

	ftrc_in_if in_ch ();
	ftrc_out_if out_ch ();

	five_tuple_rule_classifier uut (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch));

	ftrc_checker verdict_check (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .verdicts_pending(verdicts_pending));

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stall the result side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Present one request and hold it until accepted
	task automatic send_request(logic op, logic dir, logic [HIT_W-1:0] slot,
		logic [CODE_W-1:0] act, logic [CODE_W-1:0] proto, logic [ADDR_W-1:0] a1,
		logic [PORT_W-1:0] p1, logic [ADDR_W-1:0] a2, logic [PORT_W-1:0] p2);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.direction <= dir;
		in_ch.rule_slot <= slot;
		in_ch.rule_action_code <= act;
		in_ch.proto_number <= proto;
		in_ch.first_addr <= a1;
		in_ch.first_port <= p1;
		in_ch.second_addr <= a2;
		in_ch.second_port <= p2;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Drop the request line, wait for every verdict, then let a trailing write settle
	task automatic drain();
		int guard;
		guard = 0;
		in_ch.valid <= 1'b0;
		while (verdicts_pending != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (140) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [ADDR_W-1:0] pick_addr(bit wild);
		if (wild && $urandom_range(2) == 0) return '0;
		if ($urandom_range(9) == 0) return $urandom;
		return addr_pool[$urandom_range(3)];
	endfunction

	function automatic logic [PORT_W-1:0] pick_port(bit wild);
		if (wild && $urandom_range(2) == 0) return '0;
		if ($urandom_range(9) == 0) return PORT_W'($urandom);
		return port_pool[$urandom_range(3)];
	endfunction

	function automatic logic [CODE_W-1:0] pick_action();
		case ($urandom_range(4))
			0: return ACT_PERMIT_A;
			1: return ACT_PERMIT_B;
			2: return ACT_PERMIT_C;
			default: return CODE_W'($urandom);
		endcase
	endfunction

	// Random rule writes into the table
	task automatic write_random_rules(int count, int top_slot);
		for (int i = 0; i < count; i++)
			send_request(OP_WRITE, 1'($urandom), HIT_W'($urandom_range(top_slot)),
				pick_action(), proto_pool[$urandom_range(3)], pick_addr(1), pick_port(1),
				pick_addr(1), pick_port(1));
	endtask

	// Classify with headers drawn mostly from the rule pools
	task automatic classify_random(int count);
		for (int i = 0; i < count; i++)
			send_request(OP_CLASSIFY, 1'($urandom), HIT_W'($urandom), CODE_W'($urandom),
				($urandom_range(7) == 0) ? CODE_W'($urandom) : proto_pool[$urandom_range(3)],
				pick_addr(0), pick_port(0), pick_addr(0), pick_port(0));
	endtask

	initial begin
		#200ms;
		$display("** five_tuple_rule_classifier: FAILED **");
		$finish;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_WRITE;
		in_ch.direction = 1'b0;
		in_ch.rule_slot = '0;
		in_ch.rule_action_code = '0;
		in_ch.proto_number = '0;
		in_ch.first_addr = '0;
		in_ch.first_port = '0;
		in_ch.second_addr = '0;
		in_ch.second_port = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		send_idle_pct = 0;
		sink_stall_pct = 0;
		proto_pool = '{PROTO_ICMP, 8'd6, 8'd17, 8'd255};
		addr_pool = '{32'hFFFF_FFFF, 32'h0A00_0001, 32'hC0A8_0102, 32'h0000_0001};
		port_pool = '{16'hFFFF, 16'd80, 16'd443, 16'd1};
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill the whole table first, so no unwritten entry is read
		for (int s = 0; s < 64; s++)
			send_request(OP_WRITE, 1'b0, s[HIT_W-1:0], 8'd7, 8'd200, 32'd0, 16'd0, 32'd0, 16'd0);
		send_request(OP_WRITE, 1'b1, 6'd0, ACT_PERMIT_A, 8'd6, 32'hFFFF_FFFF, 16'hFFFF,
			32'h0A00_0001, 16'd80);
		send_request(OP_WRITE, 1'b0, 6'd1, 8'hFF, PROTO_ICMP, 32'hC0A8_0102, 16'd0, 32'd5, 16'd9);
		send_request(OP_WRITE, 1'b0, 6'd2, ACT_PERMIT_C, 8'd0, 32'd0, 16'd0, 32'd0, 16'd0);
		send_request(OP_WRITE, 1'b1, 6'd63, 8'd0, 8'd17, 32'd0, 16'd443, 32'd0, 16'd0);
		drain();
		write_reg(REG_RULES, 7'd64);
		// Hits both ways, ICMP outbound skipping dst, wildcard, slot 63, filler; a miss
		send_request(OP_CLASSIFY, 1'b0, '0, '0, 8'd6, 32'hFFFF_FFFF, 16'hFFFF,
			32'h0A00_0001, 16'd80);
		send_request(OP_CLASSIFY, 1'b1, '1, '1, 8'd6, 32'h0A00_0001, 16'd80,
			32'hFFFF_FFFF, 16'hFFFF);
		send_request(OP_CLASSIFY, 1'b1, '0, '0, PROTO_ICMP, 32'd3, 16'd3, 32'hC0A8_0102, 16'd2);
		send_request(OP_CLASSIFY, 1'b0, '0, '0, PROTO_ICMP, 32'hC0A8_0102, 16'd1, 32'd5, 16'd9);
		send_request(OP_CLASSIFY, 1'b0, '0, '0, 8'd0, 32'd1, 16'd1, 32'd1, 16'd1);
		send_request(OP_CLASSIFY, 1'b1, '0, '0, 8'd17, 32'd1, 16'd1, 32'd9, 16'd443);
		send_request(OP_CLASSIFY, 1'b0, '0, '0, 8'd200, 32'd1, 16'd1, 32'd9, 16'd4);
		send_request(OP_CLASSIFY, 1'b0, '0, '0, 8'd99, 32'd1, 16'd1, 32'd9, 16'd4);
		drain();
		// Extremes of the rule count and a disabled filter
		write_reg(REG_RULES, 7'd127);
		send_request(OP_CLASSIFY, 1'b0, '0, '0, 8'd99, 32'd1, 16'd1, 32'd9, 16'd4);
		drain();
		write_reg(REG_RULES, 7'd0);
		send_request(OP_CLASSIFY, 1'b0, '0, '0, 8'd6, 32'hFFFF_FFFF, 16'hFFFF,
			32'h0A00_0001, 16'd80);
		drain();
		write_reg(REG_ENABLE, 7'd0);
		write_reg(REG_RULES, 7'd64);
		send_request(OP_CLASSIFY, 1'b0, '0, '0, 8'd6, 32'hFFFF_FFFF, 16'hFFFF,
			32'h0A00_0001, 16'd80);
		drain();
		write_reg(REG_ENABLE, 7'd1);

		// Random phases under different idling, small rule counts mostly
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; sink_stall_pct = 0; end
				1: begin send_idle_pct = 86; sink_stall_pct = 0; end
				2: begin send_idle_pct = 0; sink_stall_pct = 86; end
				default: begin send_idle_pct = 23; sink_stall_pct = 23; end
			endcase
			drain();
			write_reg(REG_ENABLE, (ph == 5) ? 7'd0 : 7'd1);
			write_reg(REG_RULES, (ph == 7) ? 7'd64 : 7'($urandom_range(1, 12)));
			write_random_rules(20, (ph == 7) ? 63 : 11);
			classify_random(50);
		end
		drain();
		if (fail_count == 0)
			$display("** five_tuple_rule_classifier: PASSED **");
		else
			$display("** five_tuple_rule_classifier: FAILED **");
		$finish;
	end
endmodule

/* filelist.f */
src/ftrc_pkg.sv
src/ftrc_if.sv
src/ftrc_ram.sv
src/ftrc_queue.sv
src/ftrc_engine.sv
src/five_tuple_rule_classifier.sv
test/ftrc_checker.sv
test/five_tuple_rule_classifier_tb.sv
